>>> hw/rtl/spap_pkg.sv
// ----------------------------------------------------------------------------
// spap_pkg
// Shared types and constants of the scanline paced audio player.
// ----------------------------------------------------------------------------
`default_nettype none

package spap_pkg;

  localparam int FRAME_SAMPLES_DEF = 370;
  localparam int ADDR_W_MAX        = 10;
  localparam int LOAD_IDX_W        = 9;
  localparam int SAMPLE_W          = 8;
  localparam int VOLUME_W          = 3;
  localparam int ACC_W             = 21;
  localparam int THR_W             = 20;
  localparam int CFG_IDX_W         = 2;
  localparam int CFG_DATA_W        = 20;
  localparam int PROD_W            = 11;
  localparam int MAG_W             = 10;
  localparam int MUL_W             = 22;
  localparam int QUEUE_DEPTH       = 4;

  localparam logic [ACC_W-1:0]    FP_ONE          = 21'h10000;
  localparam logic [SAMPLE_W-1:0] MIDPOINT        = 8'h80;
  localparam logic [VOLUME_W-1:0] VOLUME_RESET    = 3'd7;
  localparam logic [THR_W-1:0]    THRESHOLD_RESET = 20'd92990;

  // reciprocal of seven, exact for magnitudes up to 896
  localparam logic [MUL_W-1:0] RECIP7       = 22'd2341;
  localparam int               RECIP7_SHIFT = 14;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_VOLUME    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOUND_EN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd2;

  typedef enum logic [0:0] {
    CMD_LOAD = 1'b0,
    CMD_PLAY = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e                    cmd;
    logic [ADDR_W_MAX-1:0]   addr;
    logic signed [PROD_W-1:0] prod;
  } cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/scanline_paced_audio_player.sv
// ----------------------------------------------------------------------------
// scanline_paced_audio_player
// Frame of audio samples played out at a pace set by scanline ticks through
// a 5.16 phase accumulator.
// ----------------------------------------------------------------------------
//  channel  handshake               payload
//  in       in_valid_i/in_stall_o   req_type_i, load_index_i, raw_sample_i
//  out      out_valid_o/out_stall_i level_o
//  cfg      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
//  one item per cycle while in_stall_o is low; a crossing tick is queued, then read into level_o, raising out_valid_o
//  after reset a clearing pass that writes zero to every frame store entry holds in_stall_o
//  the frame store has one write and one read port, one command each cycle unless the output stalls a play
//  a stalled output holds the first play command in the queue, loads behind wait
//  in_stall_o rises once the 4-entry queue is full
//  cfg_ready_o is always high
// ----------------------------------------------------------------------------
`default_nettype none

module scanline_paced_audio_player #(
  parameter int FRAME_SAMPLES = spap_pkg::FRAME_SAMPLES_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic                             req_type_i,
  input  wire logic [spap_pkg::LOAD_IDX_W-1:0]  load_index_i,
  input  wire logic [spap_pkg::SAMPLE_W-1:0]    raw_sample_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [spap_pkg::SAMPLE_W-1:0]         level_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [spap_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [spap_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import spap_pkg::*;

  logic init_busy;
  logic q_full, q_push, q_empty, q_pop;
  cmd_t q_cmd, q_head;

  assign cfg_ready_o = 1'b1;

  spap_front #(
    .FRAME_SAMPLES(FRAME_SAMPLES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .load_index_i(load_index_i),
    .raw_sample_i(raw_sample_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .init_busy_i (init_busy),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_cmd_o     (q_cmd)
  );

  spap_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (q_cmd),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .head_o (q_head)
  );

  spap_back #(
    .FRAME_SAMPLES(FRAME_SAMPLES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .init_busy_o(init_busy),
    .q_empty_i  (q_empty),
    .q_head_i   (q_head),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .level_o    (level_o)
  );

endmodule

`default_nettype wire

>>> hw/rtl/spap_front.sv
// ----------------------------------------------------------------------------
// spap_front
// Accepts items, holds the settings and the phase accumulator, and issues
// load and play commands to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module spap_front #(
  parameter int FRAME_SAMPLES = spap_pkg::FRAME_SAMPLES_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic                             req_type_i,
  input  wire logic [spap_pkg::LOAD_IDX_W-1:0]  load_index_i,
  input  wire logic [spap_pkg::SAMPLE_W-1:0]    raw_sample_i,
  input  wire logic                             cfg_valid_i,
  input  wire logic [spap_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [spap_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                             init_busy_i,
  input  wire logic                             q_full_i,
  output logic                                  q_push_o,
  output spap_pkg::cmd_t                        q_cmd_o
);
  import spap_pkg::*;

  logic [VOLUME_W-1:0] volume_q;
  logic                sound_en_q;
  logic [THR_W-1:0]    thr_q;
  logic [ACC_W-1:0]    acc_q, acc_d;
  logic [ACC_W-1:0]    acc_sum;
  logic                hit;
  logic                accept;
  logic                in_range;
  logic signed [8:0]   centered;
  logic signed [3:0]   vol_s;
  logic signed [12:0]  prod_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volume_q   <= VOLUME_RESET;
      sound_en_q <= 1'b1;
      thr_q      <= THRESHOLD_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_VOLUME:    volume_q   <= cfg_data_i[VOLUME_W-1:0];
        REG_SOUND_EN:  sound_en_q <= cfg_data_i[0];
        REG_THRESHOLD: thr_q      <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = init_busy_i | q_full_i;
  assign accept     = in_valid_i & ~in_stall_o;

  assign acc_sum  = acc_q + FP_ONE;
  assign hit      = acc_sum >= {1'b0, thr_q};
  assign in_range = 11'(load_index_i) < 11'(FRAME_SAMPLES);

  always_comb begin
    acc_d = acc_q;
    if (accept && req_type_i == REQ_TICK) begin
      acc_d = hit ? (acc_sum - {1'b0, thr_q}) : acc_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  // silence and full volume both fall out of the same scaling
  assign centered  = $signed({1'b0, raw_sample_i}) - 9'sd128;
  assign vol_s     = sound_en_q ? $signed({1'b0, volume_q}) : 4'sd0;
  assign prod_full = centered * vol_s;

  assign q_push_o = accept & ((req_type_i == REQ_LOAD) ? in_range : hit);

  always_comb begin
    q_cmd_o.cmd  = (req_type_i == REQ_TICK) ? CMD_PLAY : CMD_LOAD;
    q_cmd_o.addr = ADDR_W_MAX'(load_index_i);
    q_cmd_o.prod = prod_full[PROD_W-1:0];
  end

endmodule

`default_nettype wire

>>> hw/rtl/spap_queue.sv
// ----------------------------------------------------------------------------
// spap_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module spap_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  spap_pkg::cmd_t      cmd_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output spap_pkg::cmd_t      head_o
);
  import spap_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = count_q == CNT_W'(QUEUE_DEPTH);
  assign empty_o = count_q == '0;
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("queue pop while empty");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/spap_back.sv
// ----------------------------------------------------------------------------
// spap_back
// Frame store, clearing pass, sample scaling on write and playback read
// into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module spap_back #(
  parameter int FRAME_SAMPLES = spap_pkg::FRAME_SAMPLES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  output logic                               init_busy_o,
  input  wire logic                          q_empty_i,
  input  spap_pkg::cmd_t                     q_head_i,
  output logic                               q_pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [spap_pkg::SAMPLE_W-1:0]      level_o
);
  import spap_pkg::*;

  localparam int                AW   = (FRAME_SAMPLES > 1) ? $clog2(FRAME_SAMPLES) : 1;
  localparam logic [AW-1:0]     LAST = AW'(FRAME_SAMPLES - 1);

  logic [SAMPLE_W-1:0] mem [FRAME_SAMPLES];
  logic [SAMPLE_W-1:0] rdata_q;
  logic                pend_q, pend_d;
  logic [AW-1:0]       play_q;
  logic [AW-1:0]       clr_q;
  logic                init_busy_q;
  logic                can_play;
  logic                re;
  logic                we;
  logic [AW-1:0]       waddr;
  logic [SAMPLE_W-1:0] wdata;
  logic                neg;
  logic [PROD_W-1:0]   mag_w;
  logic [MUL_W-1:0]    mul;
  logic [SAMPLE_W-1:0] quot;
  logic [SAMPLE_W-1:0] scaled;

  assign init_busy_o = init_busy_q;

  assign can_play = ~pend_q | ~out_stall_i;
  assign q_pop_o  = ~init_busy_q & ~q_empty_i &
                    ((q_head_i.cmd == CMD_LOAD) | can_play);
  assign re       = q_pop_o & (q_head_i.cmd == CMD_PLAY);

  // truncating divide by seven of the scaled, centered sample
  assign neg    = q_head_i.prod[PROD_W-1];
  assign mag_w  = neg ? PROD_W'(-q_head_i.prod) : PROD_W'(q_head_i.prod);
  assign mul    = MUL_W'(mag_w[MAG_W-1:0]) * RECIP7;
  assign quot   = mul[RECIP7_SHIFT +: SAMPLE_W];
  assign scaled = MIDPOINT + (neg ? SAMPLE_W'(-quot) : quot);

  always_comb begin
    if (init_busy_q) begin
      we    = 1'b1;
      waddr = clr_q;
      wdata = '0;
    end else begin
      we    = q_pop_o & (q_head_i.cmd == CMD_LOAD);
      waddr = AW'(q_head_i.addr);
      wdata = scaled;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[play_q];
    end
  end

  always_comb begin
    pend_d = pend_q;
    if (re) begin
      pend_d = 1'b1;
    end else if (!out_stall_i) begin
      pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_busy_q <= 1'b1;
      clr_q       <= '0;
      play_q      <= '0;
      pend_q      <= 1'b0;
    end else begin
      if (init_busy_q) begin
        clr_q <= clr_q + 1'b1;
        if (clr_q == LAST) begin
          init_busy_q <= 1'b0;
        end
      end
      if (re) begin
        play_q <= (play_q == LAST) ? '0 : play_q + 1'b1;
      end
      pend_q <= pend_d;
    end
  end

  assign out_valid_o = pend_q;
  assign level_o     = rdata_q;

`ifndef SYNTH
  a_play_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(play_q) < FRAME_SAMPLES)
    else $error("play index beyond frame");

  a_quiet_during_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_busy_q |-> !pend_q && !q_pop_o)
    else $error("activity during clearing pass");

  a_read_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    re |=> pend_q)
    else $error("play read lost");
`endif

endmodule

`default_nettype wire
